// ===== hw/rtl/flc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flc_pkg: shared types and constants of the LRU tag cache
// Word layouts of the request and response channels, the per-cell entry
// record and the control group handed to the statistics counters.
// ----------------------------------------------------------------------------
package flc_pkg;

   localparam int TAG_W       = 48;
   localparam int DATA_W      = 64;
   localparam int CNT_W       = 32;
   localparam int CAP_W       = 7;
   localparam int ENTRIES_DEF = 64;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [0:0] {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [TAG_W-1:0]    tag;
      logic [DATA_W-1:0]   entry_data;
   } req_word_type;

   typedef struct packed {
      logic                hit;
      logic [DATA_W-1:0]   read_data;
      logic [CNT_W-1:0]    hits_total;
      logic [CNT_W-1:0]    accesses_total;
   } rsp_word_type;

   typedef struct packed {
      logic                valid;
      logic [TAG_W-1:0]    tag;
      logic [DATA_W-1:0]   data;
   } entry_type;

   typedef struct packed {
      logic                count_access;
      logic                count_hit;
   } stats_ctl_type;

   typedef struct packed {
      logic [CNT_W-1:0]    hits;
      logic [CNT_W-1:0]    accesses;
   } stats_type;

endpackage
`default_nettype wire

// ===== hw/rtl/flc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flc_cell: one slot of the recency-ordered entry chain
// Holds one entry, compares it against the incoming tag, and on a shift
// takes the entry of its more recent neighbor.
// ----------------------------------------------------------------------------
module flc_cell
   import flc_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                capture,
   input  wire [TAG_W-1:0]    cmp_tag,
   input  wire                shift,
   input  entry_type          prev_entry,
   output entry_type          entry,
   output logic               match
);

   logic                valid_ff;
   logic                valid_in;
   logic [TAG_W-1:0]    tag_ff;
   logic [TAG_W-1:0]    tag_in;
   logic [DATA_W-1:0]   data_ff;
   logic [DATA_W-1:0]   data_in;
   logic                match_ff;
   logic                match_in;

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      data_in  = data_ff;
      if (shift) begin
         valid_in = prev_entry.valid;
         tag_in   = prev_entry.tag;
         data_in  = prev_entry.data;
      end
      match_in = capture ? (valid_ff && (tag_ff == cmp_tag)) : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      data_ff <= data_in;
   end

   assign entry.valid = valid_ff;
   assign entry.tag   = tag_ff;
   assign entry.data  = data_ff;
   assign match       = match_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/flc_stats.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flc_stats: saturating lookup and hit counters
// Presents the counts including the update requested in this cycle.
// ----------------------------------------------------------------------------
module flc_stats
   import flc_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  stats_ctl_type      ctl,
   output stats_type          counts_next
);

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   logic [CNT_W-1:0] hits_ff;
   logic [CNT_W-1:0] hits_in;
   logic [CNT_W-1:0] accesses_ff;
   logic [CNT_W-1:0] accesses_in;

   always_comb begin
      hits_in     = hits_ff;
      accesses_in = accesses_ff;
      if (ctl.count_hit && (hits_ff != CNT_MAX)) begin
         hits_in = hits_ff + 1'b1;
      end
      if (ctl.count_access && (accesses_ff != CNT_MAX)) begin
         accesses_in = accesses_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff     <= '0;
         accesses_ff <= '0;
      end else begin
         hits_ff     <= hits_in;
         accesses_ff <= accesses_in;
      end
   end

   assign counts_next.hits     = hits_in;
   assign counts_next.accesses = accesses_in;

endmodule
`default_nettype wire

// ===== hw/rtl/fully_assoc_lru_tag_cache_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fully_assoc_lru_tag_cache_unit: fully associative tag cache, true LRU
// A chain of ENTRIES cells kept in recency order: cell 0 holds the most
// recent entry, the last valid cell the least recent one.
//
// Usage: request words (op, tag, entry_data) enter on req_valid/req_stall,
// one response word per request leaves on rsp_valid/rsp_stall. A word moves
// at a rising edge with valid high and stall low. Each request runs as a
// compare, then a shift: at the accepting edge every cell compares its tag
// against the request and registers a match bit; then the chain shifts
// (hit entry or new entry moves to the front), counters step and the
// response register loads, so rsp_valid rises in the cycle after acceptance.
// The compare-then-shift pair of the cell chain sets the pace: no new request
// is taken while the last one still awaits its shift. While a response is
// stalled, the block accepts no new request. csr_wr_en/csr_wr_data write
// the capacity register (zero acts as one, values above ENTRIES as
// ENTRIES); write it only while the block is idle. Synchronous reset
// empties the cache, clears both counters and sets capacity to 64; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tag_cache_unit
   import flc_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
)
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  req_word_type       req_word,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output rsp_word_type       rsp_word,
   input  wire                csr_wr_en,
   input  wire [CAP_W-1:0]    csr_wr_data
);

   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;

   // Capacity register and its effective value.
   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] eff_cap;

   // Request held during the update cycle.
   req_word_type     req_ff;
   req_word_type     req_in;
   logic             upd_ff;
   logic             upd_in;
   logic             accept;

   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;
   logic             below_cap;

   // Cell chain.
   entry_type             chain [ENTRIES];
   logic [ENTRIES-1:0]    match;
   logic [ENTRIES-1:0]    shift;
   entry_type             front;
   logic                  hit;
   logic                  is_insert;
   logic [DATA_W-1:0]     hit_data;

   stats_ctl_type    stats_ctl;
   stats_type        counts_next;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_word_type     rsp_word_ff;
   rsp_word_type     rsp_word_in;

   // A new request waits while an update is in flight or a response is
   // stuck in the output register.
   assign req_stall = upd_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign below_cap = CMP_W'(occ_ff) < eff_cap;
   assign hit       = |match;
   assign is_insert = (req_ff.op == OP_INSERT);

   // Data of the matching cell; at most one cell matches.
   always_comb begin
      hit_data = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_data = hit_data | ({DATA_W{match[i]}} & chain[i].data);
      end
   end

   // The entry that lands in cell 0: the promoted entry on a hit, the new
   // entry on an insert miss. An insert always takes the new data.
   always_comb begin
      front.valid = 1'b1;
      front.tag   = req_ff.tag;
      front.data  = is_insert ? req_ff.entry_data : hit_data;
   end

   // Cell i shifts when the hit lies at or beyond it, or on an insert miss
   // when it lies within the occupied part. With room left the chain grows
   // by one cell; when full, the least recent entry falls off the end.
   genvar gi;
   generate
      for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
         logic tail_hit;
         logic miss_shift;

         assign tail_hit   = |match[ENTRIES-1:gi];
         assign miss_shift = is_insert &&
                             ((OCC_W'(gi) < occ_ff) ||
                              ((OCC_W'(gi) == occ_ff) && below_cap));
         assign shift[gi]  = upd_ff && (hit ? tail_hit : miss_shift);

         if (gi == 0) begin : g_head
            flc_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .capture    (accept),
               .cmp_tag    (req_word.tag),
               .shift      (shift[gi]),
               .prev_entry (front),
               .entry      (chain[gi]),
               .match      (match[gi])
            );
         end else begin : g_body
            flc_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .capture    (accept),
               .cmp_tag    (req_word.tag),
               .shift      (shift[gi]),
               .prev_entry (chain[gi-1]),
               .entry      (chain[gi]),
               .match      (match[gi])
            );
         end
      end
   endgenerate

   assign stats_ctl.count_access = upd_ff && !is_insert;
   assign stats_ctl.count_hit    = upd_ff && !is_insert && hit;

   flc_stats u_stats (
      .clock       (clock),
      .reset       (reset),
      .ctl         (stats_ctl),
      .counts_next (counts_next)
   );

   always_comb begin
      capacity_in  = csr_wr_en ? csr_wr_data : capacity_ff;
      req_in       = accept ? req_word : req_ff;
      upd_in       = accept;
      occ_in       = occ_ff;
      if (upd_ff && is_insert && !hit && below_cap) begin
         occ_in = occ_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (upd_ff) begin
         rsp_valid_in               = 1'b1;
         rsp_word_in.hit            = hit;
         rsp_word_in.read_data      = (!is_insert && hit) ? hit_data : '0;
         rsp_word_in.hits_total     = counts_next.hits;
         rsp_word_in.accesses_total = counts_next.accesses;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         upd_ff       <= 1'b0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         upd_ff       <= upd_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

// ===== sim/tb_fully_assoc_lru_tag_cache_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fully_assoc_lru_tag_cache_unit: self-checking bench for the LRU tag cache
// Drives lookup and insert words through the valid/stall request channel,
// shadows the cache contents, recency order and counters in a scoreboard,
// and compares every response word field by field. It runs several capacity
// settings, with idle and stall phases on both channels and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_fully_assoc_lru_tag_cache_unit;
   import flc_pkg::*;

   // Shadow copy of the cache. Each accepted request word is turned into
   // the response word the block must return, and the responses are queued
   // in order of acceptance.
   class cache_shadow;
      logic [TAG_W-1:0]  tag_mem  [ENTRIES_DEF];
      logic [DATA_W-1:0] data_mem [ENTRIES_DEF];
      bit                live     [ENTRIES_DEF];
      int unsigned       age      [ENTRIES_DEF];
      int unsigned       fill;
      logic [CNT_W-1:0]  hits;
      logic [CNT_W-1:0]  accesses;
      logic [CAP_W-1:0]  capacity;
      rsp_word_type      rsp_due [$];
      int                errors;

      function new();
         foreach (live[i]) begin
            live[i] = 1'b0;
            age[i]  = 0;
         end
         fill     = 0;
         hits     = '0;
         accesses = '0;
         capacity = CAP_RESET;
         errors   = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = value;
      endfunction

      function int pending();
         return rsp_due.size();
      endfunction

      // Every valid entry more recent than slot s ages by one; s becomes newest.
      function void make_recent(int s);
         int unsigned r;
         r = age[s];
         foreach (live[i])
            if (live[i] && age[i] < r)
               age[i]++;
         age[s] = 0;
      endfunction

      function rsp_word_type apply_request(req_word_type w);
         rsp_word_type r;
         int           slot;
         int           victim;
         int unsigned  worst;
         int unsigned  eff;
         slot = -1;
         r    = '0;
         foreach (live[i]) begin
            if (slot < 0 && live[i] && tag_mem[i] == w.tag)
               slot = i;
         end
         if (w.op == OP_LOOKUP) begin
            if (accesses != '1)
               accesses++;
            if (slot >= 0) begin
               if (hits != '1)
                  hits++;
               make_recent(slot);
               r.read_data = data_mem[slot];
            end
         end else if (slot >= 0) begin
            data_mem[slot] = w.entry_data;
            make_recent(slot);
         end else begin
            eff = (capacity == 0) ? 1 : capacity;
            if (eff > ENTRIES_DEF)
               eff = ENTRIES_DEF;
            if (fill >= eff) begin
               // Full at the current capacity: replace the least recent entry,
               // occupancy stays where it is.
               victim = 0;
               worst  = 0;
               foreach (live[i]) begin
                  if (live[i] && age[i] >= worst) begin
                     worst  = age[i];
                     victim = i;
                  end
               end
               tag_mem[victim]  = w.tag;
               data_mem[victim] = w.entry_data;
               make_recent(victim);
            end else begin
               foreach (live[i])
                  if (live[i])
                     age[i]++;
               tag_mem[fill]  = w.tag;
               data_mem[fill] = w.entry_data;
               live[fill]     = 1'b1;
               age[fill]      = 0;
               fill++;
            end
         end
         r.hit            = (slot >= 0);
         r.hits_total     = hits;
         r.accesses_total = accesses;
         return r;
      endfunction

      function void note_request(req_word_type w);
         rsp_due.push_back(apply_request(w));
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (rsp_due.size() == 0) begin
            $error("response word with none expected: %h", got);
            errors++;
            return;
         end
         want = rsp_due.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            errors++;
         end
         if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
            errors++;
         end
         if (got.hits_total !== want.hits_total) begin
            $error("hits_total: expected %0d, actual %0d", want.hits_total, got.hits_total);
            errors++;
         end
         if (got.accesses_total !== want.accesses_total) begin
            $error("accesses_total: expected %0d, actual %0d",
                   want.accesses_total, got.accesses_total);
            errors++;
         end
      endfunction
   endclass

   // The limit leaves a wide margin over the slowest correct run before the
   // run is called hung.
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int POOL_SIZE   = 96;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_word_type     req_word    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_word_type     rsp_word;
   logic             csr_wr_en   = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   cache_shadow      shadow = new();

   // Pacing knobs. idle_pct is used by the sender only; stall_pct and
   // hold_start are written at falling edges and read by the receiver at
   // rising edges, so there is no race between the two processes.
   int               idle_pct   = 0;
   int               stall_pct  = 0;
   bit               hold_start = 1'b0;
   int               hold_left  = 0;
   int               cycles     = 0;

   logic [TAG_W-1:0] tag_pool [POOL_SIZE];

   fully_assoc_lru_tag_cache_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watch both channels and the capacity port at every rising edge. The
   // request is noted before the response is checked, although a response
   // can never belong to a word accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            shadow.set_capacity(csr_wr_data);
         if (req_valid && !req_stall)
            shadow.note_request(req_word);
         if (rsp_valid && !rsp_stall)
            shadow.check_response(rsp_word);
      end
   end

   // Receiver. A hold-off, once asked for, keeps stall high until its countdown
   // here runs out; otherwise stall is drawn at random.
   always @(posedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: a hung block ends the run as a failure.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [TAG_W-1:0] random_tag();
      logic [63:0] t;
      t = {$urandom, $urandom};
      return t[TAG_W-1:0];
   endfunction

   // Offer one request word and return at the edge that accepts it. Idle
   // cycles, if any, come before the word is raised, so valid is never
   // dropped and raised in the same step.
   task automatic send_word(input op_type op, input logic [TAG_W-1:0] tag,
                            input logic [DATA_W-1:0] data);
      req_word_type w;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      w.op         = op;
      w.tag        = tag;
      w.entry_data = data;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Stop offering and wait at falling edges until every response is in,
   // then resume at a rising edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (shadow.pending() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // Capacity is written only with the block idle: drained, then a wait for
   // the compare-and-shift request pipeline to settle.
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One random phase. Most tags come from a pool a little larger than the
   // capacity, so hits, updates and evictions are all frequent; one in ten
   // is a fresh full-width tag.
   task automatic run_phase(input logic [CAP_W-1:0] cap, input int idle, input int stall,
                            input int count, input bit with_hold);
      int     eff;
      int     pool_n;
      op_type op;
      logic [TAG_W-1:0] tag;
      write_capacity(cap);
      eff = (cap == 0) ? 1 : cap;
      if (eff > ENTRIES_DEF)
         eff = ENTRIES_DEF;
      pool_n = eff + eff / 2 + 2;
      if (pool_n > POOL_SIZE)
         pool_n = POOL_SIZE;
      @(negedge clock);
      idle_pct  = idle;
      stall_pct = stall;
      if (with_hold)
         hold_start = 1'b1;
      @(posedge clock);
      for (int i = 0; i < count; i++) begin
         // Halfway through a hold phase the sender pauses until the block
         // has returned everything it owes.
         if (with_hold && i == count / 2)
            wait_drained();
         op  = $urandom_range(1) ? OP_INSERT : OP_LOOKUP;
         tag = ($urandom_range(9) == 0) ? random_tag() : tag_pool[$urandom_range(pool_n - 1)];
         send_word(op, tag, {$urandom, $urandom});
      end
   endtask

   initial begin
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         tag_pool[i] = random_tag();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset capacity of 64. A lookup into the empty
      // cache, then the extreme tags and data words, an update in place,
      // and a miss on an absent tag.
      send_word(OP_LOOKUP, '0, '1);
      send_word(OP_INSERT, '0, '0);
      send_word(OP_INSERT, '1, '1);
      send_word(OP_LOOKUP, '0, '1);
      send_word(OP_LOOKUP, '1, '0);
      send_word(OP_INSERT, '1, 64'h5555_5555_5555_5555);
      send_word(OP_LOOKUP, '1, '0);
      send_word(OP_INSERT, '0, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(OP_LOOKUP, 48'hAAAA_AAAA_AAAA, '0);
      send_word(OP_INSERT, 48'h1, 64'h1);
      send_word(OP_INSERT, 48'h2, 64'h2);

      // Capacity zero acts as one, and four entries are already held:
      // nothing is dropped, but every insert miss now replaces the least
      // recent entry.
      write_capacity(7'd0);
      send_word(OP_INSERT, 48'h3, 64'h3);
      send_word(OP_LOOKUP, 48'h3, '0);
      send_word(OP_LOOKUP, '0, '0);
      send_word(OP_INSERT, 48'h4, 64'h4);
      send_word(OP_LOOKUP, 48'h3, '0);
      send_word(OP_LOOKUP, 48'h4, '0);

      // Capacity above the entry count saturates to it.
      write_capacity(7'd127);
      send_word(OP_INSERT, 48'h5, 64'h5);
      send_word(OP_LOOKUP, 48'h1, '0);
      send_word(OP_LOOKUP, 48'h5, '0);

      // Random phases, cycling through the pacing patterns. The small
      // capacities after the large ones start with the cache over-full.
      run_phase(7'd64,  0,  0,  200, 1'b0);
      run_phase(7'd1,   49, 0,  100, 1'b0);
      run_phase(7'd4,   0,  49, 150, 1'b0);
      run_phase(7'd127, 16, 16, 150, 1'b0);
      run_phase(7'd8,   0,  0,  150, 1'b1);
      run_phase(7'd65,  49, 0,  150, 1'b0);
      run_phase(7'd3,   0,  49, 150, 1'b0);
      run_phase(7'($urandom_range(1, 64)), 16, 16, 150, 1'b0);
      run_phase(7'd0,   0,  0,  150, 1'b0);

      wait_drained();
      repeat (10) @(posedge clock);
      if (shadow.errors == 0 && shadow.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
